/* design/sapq_pkg.sv */
// ----------------------------------------------------------------------------
// sapq_pkg: shared types and constants of the sorted-array priority queue
// Request kinds, status codes, cell commands and default sizing.
// ----------------------------------------------------------------------------
package sapq_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 7;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      op_type                    op;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

endpackage

/* design/sorted_array_max_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_array_max_priority_queue_unit: max priority queue on a row of cells
// Result: the result word of an accepted request is registered and shows on
//   rsp_* in the cycle after the request is taken.
// Throughput: 1 request per cycle; every cell compares and shifts in parallel,
//   so only the result register's handshake can stall the request side.
// Reset: count and result valid clear at the reset edge; entry slots are not
//   cleared.
// ----------------------------------------------------------------------------
module sorted_array_max_priority_queue_unit #(
   parameter int DEPTH = sapq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic signed [sapq_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [sapq_pkg::VALUE_W-1:0] rsp_max_value,
   output logic                                rsp_empty_res,
   output logic [sapq_pkg::COUNT_W-1:0]        rsp_count,
   output logic [1:0]                          rsp_status
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   // Ranks run from the top: cell 0 always holds the maximum, cell k the
   // (k+1)-th largest entry. Cells at rank >= count hold stale words.
   logic [CNT_W-1:0]                    count_ff;
   logic [CNT_W-1:0]                    count_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic signed [sapq_pkg::VALUE_W-1:0] rsp_max_ff;
   logic signed [sapq_pkg::VALUE_W-1:0] rsp_max_in;
   logic                                rsp_empty_ff;
   logic                                rsp_empty_in;
   logic [sapq_pkg::COUNT_W-1:0]        rsp_count_ff;
   logic [sapq_pkg::COUNT_W-1:0]        rsp_count_in;
   sapq_pkg::status_type                rsp_status_ff;
   sapq_pkg::status_type                rsp_status_in;

   logic                                accept;
   logic                                full;
   logic                                empty;
   sapq_pkg::cmd_type                   cmd;
   logic [CNT_W+sapq_pkg::COUNT_W-1:0]  count_ext;

   logic                                cell_gt    [DEPTH];
   logic signed [sapq_pkg::VALUE_W-1:0] cell_value [DEPTH];
   logic signed [sapq_pkg::VALUE_W-1:0] cell_next  [DEPTH];
   logic signed [sapq_pkg::VALUE_W-1:0] top_next;

   // Result register parts the two sides: a new request is taken whenever the
   // held result word leaves in the same cycle or none is held.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);

   // Decode the request into a cell command; refused requests hold the row.
   always_comb begin
      cmd.value     = req_value;
      cmd.op        = sapq_pkg::OP_HOLD;
      count_in      = count_ff;
      rsp_status_in = sapq_pkg::ST_OK;
      unique case (sapq_pkg::kind_type'(req_kind))
         sapq_pkg::KIND_INSERT: begin
            if (full) begin
               rsp_status_in = sapq_pkg::ST_FULL;
            end else begin
               cmd.op   = sapq_pkg::OP_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         sapq_pkg::KIND_DELETE: begin
            if (empty) begin
               rsp_status_in = sapq_pkg::ST_EMPTY;
            end else begin
               cmd.op   = sapq_pkg::OP_DELETE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         sapq_pkg::KIND_CLEAR: begin
            cmd.op   = sapq_pkg::OP_CLEAR;
            count_in = '0;
         end
         default: begin
            // unused kind code: queue untouched, status ok
            cmd.op = sapq_pkg::OP_HOLD;
         end
      endcase
      if (!accept) begin
         cmd.op   = sapq_pkg::OP_HOLD;
         count_in = count_ff;
      end
   end

   // Row of cells. Cell 0 sees a "greater" neighbor on its left so an insert
   // that beats everything lands there; the last cell pulls its own word on a
   // delete, which only ever lands in an unused rank.
   genvar j;
   generate
      for (j = 0; j < DEPTH; j++) begin : g_cell
         if (j == 0) begin : g_head
            sapq_cell #(.DEPTH(DEPTH), .IDX(j)) u_cell (
               .clock       (clock),
               .cmd         (cmd),
               .count       (count_ff),
               .left_gt     (1'b1),
               .left_value  (cell_value[j]),
               .right_value (cell_value[j+1]),
               .gt          (cell_gt[j]),
               .value       (cell_value[j]),
               .value_next  (cell_next[j])
            );
         end else if (j == DEPTH - 1) begin : g_tail
            sapq_cell #(.DEPTH(DEPTH), .IDX(j)) u_cell (
               .clock       (clock),
               .cmd         (cmd),
               .count       (count_ff),
               .left_gt     (cell_gt[j-1]),
               .left_value  (cell_value[j-1]),
               .right_value (cell_value[j]),
               .gt          (cell_gt[j]),
               .value       (cell_value[j]),
               .value_next  (cell_next[j])
            );
         end else begin : g_body
            sapq_cell #(.DEPTH(DEPTH), .IDX(j)) u_cell (
               .clock       (clock),
               .cmd         (cmd),
               .count       (count_ff),
               .left_gt     (cell_gt[j-1]),
               .left_value  (cell_value[j-1]),
               .right_value (cell_value[j+1]),
               .gt          (cell_gt[j]),
               .value       (cell_value[j]),
               .value_next  (cell_next[j])
            );
         end
      end
   endgenerate

   // next word of the head cell is the maximum after this request
   assign top_next = cell_next[0];

   // Result word reflects the queue after this request.
   assign count_ext    = {{sapq_pkg::COUNT_W{1'b0}}, count_in};
   assign rsp_count_in = count_ext[sapq_pkg::COUNT_W-1:0];
   assign rsp_empty_in = (count_in == '0);
   assign rsp_max_in   = rsp_empty_in ? '0 : top_next;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: loaded on every accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_max_ff    <= rsp_max_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_max_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count beyond depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == sapq_pkg::KIND_INSERT && !full) |=>
         (count_ff == $past(count_ff) + CNT_W'(1)) && rsp_valid_ff &&
         (rsp_status_ff == sapq_pkg::ST_OK))
      else $error("accepted insert did not grow the queue");

   a_refuse_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && ((req_kind == sapq_pkg::KIND_INSERT && full) ||
                  (req_kind == sapq_pkg::KIND_DELETE && empty))) |=>
         (count_ff == $past(count_ff)) && (rsp_status_ff != sapq_pkg::ST_OK))
      else $error("refused request changed the queue");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_max_ff == '0))
      else $error("empty result carries a nonzero maximum");

   a_no_accept_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while result word is stalled");

endmodule

/* design/sapq_cell.sv */
// ----------------------------------------------------------------------------
// sapq_cell: one slot of the queue row
// Holds one entry; rank IDX counted from the top. Inserts push smaller or equal entries
// toward higher ranks, deletes pull every entry one rank toward the top.
// ----------------------------------------------------------------------------
module sapq_cell #(
   parameter int DEPTH = sapq_pkg::DEPTH_DEFAULT,
   parameter int IDX   = 0,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                                clock,
   input  sapq_pkg::cmd_type                   cmd,
   input  logic [CNT_W-1:0]                    count,
   input  logic                                left_gt,
   input  logic signed [sapq_pkg::VALUE_W-1:0] left_value,
   input  logic signed [sapq_pkg::VALUE_W-1:0] right_value,
   output logic                                gt,
   output logic signed [sapq_pkg::VALUE_W-1:0] value,
   output logic signed [sapq_pkg::VALUE_W-1:0] value_next
);

   localparam logic [CNT_W-1:0] RANK = CNT_W'(IDX);

   logic signed [sapq_pkg::VALUE_W-1:0] value_ff;
   logic signed [sapq_pkg::VALUE_W-1:0] value_in;
   logic                                occupied;

   // entry stays put when it outranks the new word
   assign occupied = (RANK < count);
   assign gt       = occupied && (value_ff > cmd.value);

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         sapq_pkg::OP_INSERT: begin
            if (!gt) begin
               value_in = left_gt ? cmd.value : left_value;
            end
         end
         sapq_pkg::OP_DELETE: begin
            value_in = right_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign value_next = value_in;

endmodule

/* tb/sv/tb_sorted_array_max_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// tb_sorted_array_max_priority_queue_unit: self-checking bench for the queue
// Drives insert, delete-max, clear and unused-kind request words. A shadow
// queue predicts each response word, and a monitor compares responses in
// order. The run has a short directed part, then random traffic that
// alternately fills the queue past full and drains it past empty, under
// several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_sorted_array_max_priority_queue_unit;

   localparam int DEPTH   = sapq_pkg::DEPTH_DEFAULT;
   localparam int VALUE_W = sapq_pkg::VALUE_W;
   localparam int COUNT_W = sapq_pkg::COUNT_W;
   // kind code 3 has no name in the package; the block must ignore it
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int PHASE_WORDS = 95;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic signed [VALUE_W-1:0] max_value;
      logic                      empty_res;
      logic [COUNT_W-1:0]        count;
      sapq_pkg::status_type      status;
   } queue_result_type;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_kind  = 2'd0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_max_value;
   logic                      rsp_empty_res;
   logic [COUNT_W-1:0]        rsp_count;
   logic [1:0]                rsp_status;

   // shadow copy of the queue: ascending over slots 0..shadow_count-1
   logic signed [VALUE_W-1:0] shadow_slots [DEPTH];
   int                        shadow_count = 0;
   queue_result_type          expected_results[$];

   // idle mix of the current phase, in percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   int  words_sent     = 0;
   int  words_checked  = 0;
   int  mismatch_count = 0;
   int  full_refusals  = 0;
   int  empty_refusals = 0;
   int  peak_count     = 0;
   bit  climbing       = 1'b1;
   int  edge_hits      = 0;

   sorted_array_max_priority_queue_unit #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_max_value(rsp_max_value),
      .rsp_empty_res(rsp_empty_res),
      .rsp_count    (rsp_count),
      .rsp_status   (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop: far above the slowest legal run of ~400 words under the heaviest stall mix.
   initial begin
      #400000;
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Shadow queue update: applies one request and returns the response word
   // the block should give for it.
   // ------------------------------------------------------------------------
   function automatic void predict_queue_state(
      input  logic [1:0]                kind,
      input  logic signed [VALUE_W-1:0] value,
      output queue_result_type          res
   );
      int pos;
      sapq_pkg::status_type st;
      st = sapq_pkg::ST_OK;
      if (kind == sapq_pkg::KIND_INSERT) begin
         if (shadow_count >= DEPTH) begin
            st = sapq_pkg::ST_FULL;
            full_refusals++;
         end else begin
            // larger entries move up one slot; equal ones stay below
            pos = shadow_count;
            while (pos > 0 && shadow_slots[pos-1] > value) begin
               shadow_slots[pos] = shadow_slots[pos-1];
               pos--;
            end
            shadow_slots[pos] = value;
            shadow_count++;
         end
      end else if (kind == sapq_pkg::KIND_DELETE) begin
         if (shadow_count == 0) begin
            st = sapq_pkg::ST_EMPTY;
            empty_refusals++;
         end else begin
            shadow_count--;
         end
      end else if (kind == sapq_pkg::KIND_CLEAR) begin
         shadow_count = 0;
      end
      // unused kind: queue untouched, status stays ok
      if (shadow_count > peak_count) peak_count = shadow_count;
      res.max_value = (shadow_count > 0) ? shadow_slots[shadow_count-1] : '0;
      res.empty_res = (shadow_count == 0);
      res.count     = shadow_count[COUNT_W-1:0];
      res.status    = st;
   endfunction

   // ------------------------------------------------------------------------
   // Sender: optional idle gap, then hold the word until it is taken. The
   // expectation is queued at the accepting edge.
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [1:0] kind,
                            input logic signed [VALUE_W-1:0] value);
      queue_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      predict_queue_state(kind, value, res);
      expected_results.push_back(res);
      words_sent++;
   endtask

   // Sender goes quiet until every outstanding response has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random backpressure at the phase's stall rate.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string what, input queue_result_type exp_res);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("MISMATCH %s: exp max=%0d empty=%0b count=%0d status=%0d",
                  what, exp_res.max_value, exp_res.empty_res, exp_res.count,
                  exp_res.status);
         $display("   got max=%0d empty=%0b count=%0d status=%0d",
                  rsp_max_value, rsp_empty_res, rsp_count, rsp_status);
      end
   endtask

   // Monitor: every accepted response word against the oldest expectation.
   always @(posedge clock) begin : response_monitor
      queue_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            exp_res = '0;
            report_mismatch("unexpected word", exp_res);
         end else begin
            exp_res = expected_results.pop_front();
            words_checked++;
            if (rsp_max_value !== exp_res.max_value ||
                rsp_empty_res !== exp_res.empty_res ||
                rsp_count !== exp_res.count || rsp_status !== exp_res.status)
               report_mismatch("field", exp_res);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Random content
   // ------------------------------------------------------------------------
   function automatic logic signed [VALUE_W-1:0] random_value();
      int roll;
      roll = $urandom_range(15);
      case (roll)
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return -32'sd1;
         4, 5, 6, 7: return $signed($urandom_range(16)) - 8;   // dense, many duplicates
         default: return $urandom;
      endcase
   endfunction

   // rising mix pushes toward full, falling mix toward empty
   function automatic logic [1:0] random_kind(input bit rising);
      int roll;
      roll = $urandom_range(99);
      if (roll < 2) return KIND_UNUSED;
      if (!rising && roll < 5) return sapq_pkg::KIND_CLEAR;
      if (rising) return (roll < 87) ? sapq_pkg::KIND_INSERT : sapq_pkg::KIND_DELETE;
      return (roll < 25) ? sapq_pkg::KIND_INSERT : sapq_pkg::KIND_DELETE;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_kinds_and_extremes();
      send_word(sapq_pkg::KIND_INSERT, 32'sd5);
      send_word(sapq_pkg::KIND_INSERT, -32'sd3);
      send_word(sapq_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
      send_word(sapq_pkg::KIND_INSERT, 32'sh8000_0000);
      send_word(sapq_pkg::KIND_INSERT, 32'shAAAA_AAAA);
      send_word(sapq_pkg::KIND_INSERT, 32'sh5555_5555);
      send_word(sapq_pkg::KIND_DELETE, $urandom);
      send_word(sapq_pkg::KIND_DELETE, $urandom);
      send_word(sapq_pkg::KIND_CLEAR, $urandom);
      send_word(sapq_pkg::KIND_CLEAR, '0);             // clear of an empty queue
   endtask

   task automatic test_empty_delete();
      send_word(sapq_pkg::KIND_DELETE, '0);
      send_word(sapq_pkg::KIND_DELETE, -32'sd1);
   endtask

   // equal values: order among them is invisible, but the top must hold
   task automatic test_duplicate_values();
      send_word(sapq_pkg::KIND_INSERT, 32'sd7);
      send_word(sapq_pkg::KIND_INSERT, 32'sd7);
      send_word(sapq_pkg::KIND_INSERT, -32'sd1);
      send_word(sapq_pkg::KIND_INSERT, 32'sd7);
      send_word(sapq_pkg::KIND_DELETE, '0);
      send_word(sapq_pkg::KIND_DELETE, '0);
      send_word(sapq_pkg::KIND_DELETE, '0);
   endtask

   task automatic test_unused_kind();
      send_word(KIND_UNUSED, 32'sh7FFF_FFFF);   // on a non-empty queue
      send_word(sapq_pkg::KIND_CLEAR, '0);
      send_word(KIND_UNUSED, 32'sh8000_0000);   // on an empty queue
   endtask

   // Random traffic: climb until full, keep pushing a few refused inserts,
   // then drain until empty and keep deleting a few times, and repeat.
   task automatic test_fill_and_drain(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < PHASE_WORDS; i++) begin
         if (climbing && shadow_count == DEPTH) begin
            edge_hits++;
            if (edge_hits > 3) begin
               climbing  = 1'b0;
               edge_hits = 0;
            end
         end else if (!climbing && shadow_count == 0) begin
            edge_hits++;
            if (edge_hits > 3) begin
               climbing  = 1'b1;
               edge_hits = 0;
            end
         end
         send_word(random_kind(climbing), random_value());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_kinds_and_extremes();
      test_empty_delete();
      test_duplicate_values();
      test_unused_kind();

      test_fill_and_drain(0, 0);
      hold_until_drained();
      test_fill_and_drain(60, 0);
      test_fill_and_drain(0, 60);
      hold_until_drained();
      test_fill_and_drain(17, 17);

      // let the tail drain, then wait quietly for stray words
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("covered: %0d words sent, %0d responses checked, peak occupancy %0d of %0d",
               words_sent, words_checked, peak_count, DEPTH);
      $display("covered: %0d inserts refused at full, %0d deletes refused at empty",
               full_refusals, empty_refusals);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
